/* sv/lpr_pkg.sv */
// ---------------------------------------------------------------------------
// lpr_pkg
// Types and fixed field widths shared by the route lookup unit and its checker.
// ---------------------------------------------------------------------------
package lpr_pkg;

   // Fixed field widths of the configuration, request and response ports
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned IFACE_W = 8;
   localparam int unsigned SLOT_W  = 6;
   localparam int unsigned COUNT_W = 7;

   // Operation codes of a request
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // One routing table entry as held in the table memory
   typedef struct packed {
      logic [ADDR_W-1:0]  prefix;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  gateway;
      logic [IFACE_W-1:0] iface;
   } entry_type;

endpackage

/* sv/longest_prefix_route_lookup_unit.sv */
// A lookup scans min(entries_in_use, TABLE_DEPTH) entries, then a finish state registers
// the response; busy covers both, so no request is taken mid-lookup. Writes give no
// response and leave busy low. The scan rate is set by the single table memory read
// port, one entry per cycle, feeding one shared compare unit. Synchronous active-high
// reset clears the sequencer and entries_in_use; table contents are not cleared.
// Responses cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// Linear longest-prefix-match route table: stores prefix/mask/next hop/interface
// entries and scans them one per cycle for the best match of a destination address.
// ---------------------------------------------------------------------------
module longest_prefix_route_lookup_unit #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [lpr_pkg::COUNT_W-1:0]    csr_wr_data,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [lpr_pkg::SLOT_W-1:0]     req_entry_index,
   input  logic [lpr_pkg::ADDR_W-1:0]     req_entry_prefix,
   input  logic [lpr_pkg::ADDR_W-1:0]     req_entry_mask,
   input  logic [lpr_pkg::ADDR_W-1:0]     req_entry_next_hop,
   input  logic [lpr_pkg::IFACE_W-1:0]    req_entry_interface,
   input  logic [lpr_pkg::ADDR_W-1:0]     req_dest_address,
   // response channel
   output logic                           rsp_strobe,
   output logic                           rsp_route_found,
   output logic [lpr_pkg::SLOT_W-1:0]     rsp_route_index,
   output logic [lpr_pkg::ADDR_W-1:0]     rsp_route_next_hop,
   output logic [lpr_pkg::IFACE_W-1:0]    rsp_route_interface
);

   localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned LIM_W0 = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned LIM_W  = (LIM_W0 > lpr_pkg::COUNT_W) ? LIM_W0 : lpr_pkg::COUNT_W;

   // table memory
   lpr_pkg::entry_type route_mem [TABLE_DEPTH];

   lpr_pkg::state_type state_ff, state_in;

   logic [lpr_pkg::COUNT_W-1:0] count_ff;
   logic [lpr_pkg::ADDR_W-1:0]  dest_ff, dest_in;
   logic [IDX_W-1:0]            addr_ff, addr_in;
   logic [IDX_W-1:0]            last_ff, last_in;
   lpr_pkg::entry_type          rd_data_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic                        rd_vld_ff, rd_vld_in;

   logic                        found_ff, found_in;
   logic [lpr_pkg::ADDR_W-1:0]  best_mask_ff, best_mask_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [lpr_pkg::ADDR_W-1:0]  best_nh_ff, best_nh_in;
   logic [lpr_pkg::IFACE_W-1:0] best_if_ff, best_if_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic                        rsp_found_ff;
   logic [lpr_pkg::SLOT_W-1:0]  rsp_index_ff;
   logic [lpr_pkg::ADDR_W-1:0]  rsp_nh_ff;
   logic [lpr_pkg::IFACE_W-1:0] rsp_if_ff;

   logic                        accept;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   lpr_pkg::entry_type          wr_entry;
   logic [LIM_W-1:0]            count_ext;
   logic [LIM_W-1:0]            limit;
   logic                        hit;

   assign busy   = (state_ff != lpr_pkg::ST_IDLE);
   assign accept = start && !busy;

   // entry write decode; slots past the table depth are dropped
   assign wr_en   = accept && (req_operation == lpr_pkg::OP_WRITE)
                    && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr = IDX_W'(req_entry_index);
   assign wr_entry = '{prefix:   req_entry_prefix,
                       mask:     req_entry_mask,
                       gateway:  req_entry_next_hop,
                       iface:    req_entry_interface};

   // entries searched, saturated at the table depth
   assign count_ext = LIM_W'(count_ff);
   assign limit     = (count_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : count_ext;

   // shared match unit: prefix match and strictly greater mask value than the current best
   assign hit = rd_vld_ff
                && ((dest_ff & rd_data_ff.mask) == rd_data_ff.prefix)
                && (!found_ff || (rd_data_ff.mask > best_mask_ff));

   // best-match tracking
   always_comb begin
      found_in     = found_ff;
      best_mask_in = best_mask_ff;
      best_idx_in  = best_idx_ff;
      best_nh_in   = best_nh_ff;
      best_if_in   = best_if_ff;
      if (hit) begin
         found_in     = 1'b1;
         best_mask_in = rd_data_ff.mask;
         best_idx_in  = rd_idx_ff;
         best_nh_in   = rd_data_ff.gateway;
         best_if_in   = rd_data_ff.iface;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      dest_in       = dest_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      rd_vld_in     = 1'b0;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         lpr_pkg::ST_IDLE: begin
            if (accept && (req_operation == lpr_pkg::OP_LOOKUP)) begin
               dest_in  = req_dest_address;
               addr_in  = '0;
               last_in  = IDX_W'(limit - LIM_W'(1));
               state_in = (limit == '0) ? lpr_pkg::ST_FINISH : lpr_pkg::ST_SCAN;
            end
         end
         lpr_pkg::ST_SCAN: begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + IDX_W'(1);
            if (addr_ff == last_ff) begin
               state_in = lpr_pkg::ST_FINISH;
            end
         end
         lpr_pkg::ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            state_in      = lpr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lpr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpr_pkg::ST_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         // a new lookup starts with no match
         if (state_ff == lpr_pkg::ST_IDLE) begin
            found_ff <= 1'b0;
         end else begin
            found_ff <= found_in;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dest_ff      <= dest_in;
      addr_ff      <= addr_in;
      last_ff      <= last_in;
      rd_idx_ff    <= addr_ff;
      best_mask_ff <= best_mask_in;
      best_idx_ff  <= best_idx_in;
      best_nh_ff   <= best_nh_in;
      best_if_ff   <= best_if_in;
      // response capture, zeros when nothing matched
      if (state_ff == lpr_pkg::ST_FINISH) begin
         rsp_found_ff <= found_in;
         rsp_index_ff <= found_in ? lpr_pkg::SLOT_W'(best_idx_in) : '0;
         rsp_nh_ff    <= found_in ? best_nh_in : '0;
         rsp_if_ff    <= found_in ? best_if_in : '0;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_addr] <= wr_entry;
      end
      if (state_ff == lpr_pkg::ST_SCAN) begin
         rd_data_ff <= route_mem[addr_ff];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_route_found     = rsp_found_ff;
   assign rsp_route_index     = rsp_index_ff;
   assign rsp_route_next_hop  = rsp_nh_ff;
   assign rsp_route_interface = rsp_if_ff;

endmodule

/* sv/lpr_checker.sv */
// ---------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the route lookup unit, bound into the route lookup unit module.
// ---------------------------------------------------------------------------
module lpr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_operation,
   input logic                         rsp_strobe,
   input logic                         rsp_route_found,
   input logic [lpr_pkg::SLOT_W-1:0]   rsp_route_index,
   input logic [lpr_pkg::ADDR_W-1:0]   rsp_route_next_hop,
   input logic [lpr_pkg::IFACE_W-1:0]  rsp_route_interface
);

   // an accepted lookup makes the unit busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == lpr_pkg::OP_LOOKUP) |=> busy)
      else $error("lookup accepted but unit not busy");

   // an accepted write completes at once with no response
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == lpr_pkg::OP_WRITE) |=> (!busy && !rsp_strobe))
      else $error("write request caused busy or a response");

   // a response ends a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a preceding lookup");

   // responses never come on consecutive cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back responses");

   // a miss reports all-zero route fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_route_found) |->
         (rsp_route_index == '0 && rsp_route_next_hop == '0 && rsp_route_interface == '0))
      else $error("miss response with nonzero route fields");

endmodule

bind longest_prefix_route_lookup_unit lpr_checker u_lpr_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_operation       (req_operation),
   .rsp_strobe          (rsp_strobe),
   .rsp_route_found     (rsp_route_found),
   .rsp_route_index     (rsp_route_index),
   .rsp_route_next_hop  (rsp_route_next_hop),
   .rsp_route_interface (rsp_route_interface)
);

/* tb/longest_prefix_route_lookup_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup_unit_tb
// Self-checking bench for the linear longest-prefix route table. Table writes
// and address lookups are issued over the start/busy request port with random
// gaps. A local route table mirrors every accepted write and works out the
// best route of each lookup. A monitor compares each strobed response, field
// by field, with the oldest pending route. The entry count register is changed
// between phases only, with the unit idle: zero, one, full depth and values
// past the depth are all used.
// ---------------------------------------------------------------------------
module longest_prefix_route_lookup_unit_tb;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_LIMIT = 2_000;
   localparam int SETTLE      = 4;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 92;

   // Expected lookup response
   typedef struct packed {
      logic                        found;
      logic [lpr_pkg::SLOT_W-1:0]  index;
      logic [lpr_pkg::ADDR_W-1:0]  gateway;
      logic [lpr_pkg::IFACE_W-1:0] iface;
   } route_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   logic [lpr_pkg::COUNT_W-1:0]  csr_wr_data;
   logic                         start;
   logic                         busy;
   logic                         req_operation;
   logic [lpr_pkg::SLOT_W-1:0]   req_entry_index;
   logic [lpr_pkg::ADDR_W-1:0]   req_entry_prefix;
   logic [lpr_pkg::ADDR_W-1:0]   req_entry_mask;
   logic [lpr_pkg::ADDR_W-1:0]   req_entry_next_hop;
   logic [lpr_pkg::IFACE_W-1:0]  req_entry_interface;
   logic [lpr_pkg::ADDR_W-1:0]   req_dest_address;
   logic                         rsp_strobe;
   logic                         rsp_route_found;
   logic [lpr_pkg::SLOT_W-1:0]   rsp_route_index;
   logic [lpr_pkg::ADDR_W-1:0]   rsp_route_next_hop;
   logic [lpr_pkg::IFACE_W-1:0]  rsp_route_interface;

   // Mirror of the table and of the count register
   lpr_pkg::entry_type           route_table [DEPTH];
   logic [lpr_pkg::COUNT_W-1:0]  active_entries;
   route_type                    pending_routes [$];
   route_type                    want_route;

   int  error_count;
   int  cycle_count;
   int  write_count;
   int  lookup_count;
   int  routed_count;
   int  count_settings;
   bit  burst_mode;

   longest_prefix_route_lookup_unit #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_entry_index     (req_entry_index),
      .req_entry_prefix    (req_entry_prefix),
      .req_entry_mask      (req_entry_mask),
      .req_entry_next_hop  (req_entry_next_hop),
      .req_entry_interface (req_entry_interface),
      .req_dest_address    (req_dest_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_route_found     (rsp_route_found),
      .rsp_route_index     (rsp_route_index),
      .rsp_route_next_hop  (rsp_route_next_hop),
      .rsp_route_interface (rsp_route_interface)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, want);
   endtask

   // Best route for a destination: greatest mask wins, lowest slot on a tie
   function automatic route_type best_route(input logic [lpr_pkg::ADDR_W-1:0] dest);
      route_type r;
      int        limit;
      r = '0;
      limit = (active_entries > DEPTH) ? DEPTH : int'(active_entries);
      for (int i = 0; i < limit; i++) begin
         if ((dest & route_table[i].mask) == route_table[i].prefix) begin
            if (!r.found || route_table[i].mask > route_table[r.index].mask) begin
               r.found = 1'b1;
               r.index = i[lpr_pkg::SLOT_W-1:0];
            end
         end
      end
      if (r.found) begin
         r.gateway = route_table[r.index].gateway;
         r.iface   = route_table[r.index].iface;
      end
      return r;
   endfunction

   // Random entry: mostly contiguous masks, some odd masks, dead entries, ties
   function automatic lpr_pkg::entry_type make_entry();
      lpr_pkg::entry_type e;
      int                 kind;
      int                 len;
      int                 src;
      kind      = $urandom_range(0, 9);
      e.gateway = $urandom;
      e.iface   = lpr_pkg::IFACE_W'($urandom_range(0, 255));
      if (kind <= 6) begin
         len      = $urandom_range(0, 32);
         e.mask   = (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
         e.prefix = $urandom & e.mask;
      end else if (kind == 7) begin
         e.mask   = $urandom;
         e.prefix = $urandom & e.mask;
      end else if (kind == 8) begin
         e.mask   = $urandom;
         e.prefix = $urandom;
      end else begin
         src      = $urandom_range(0, DEPTH - 1);
         e.mask   = route_table[src].mask;
         e.prefix = route_table[src].prefix;
      end
      return e;
   endfunction

   // Destination aimed at a searched entry most of the time
   function automatic logic [lpr_pkg::ADDR_W-1:0] pick_dest();
      int                         limit;
      int                         s;
      logic [lpr_pkg::ADDR_W-1:0] d;
      limit = (active_entries > DEPTH) ? DEPTH : int'(active_entries);
      d = $urandom;
      if (limit > 0 && $urandom_range(0, 3) != 0) begin
         s = $urandom_range(0, limit - 1);
         d = route_table[s].prefix | (d & ~route_table[s].mask);
      end else if ($urandom_range(0, 7) == 0) begin
         d = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      return d;
   endfunction

   // Issue one request and wait for its acceptance; start stays high on return
   task automatic send_request(input logic op, input logic [lpr_pkg::SLOT_W-1:0] slot,
                               input lpr_pkg::entry_type e,
                               input logic [lpr_pkg::ADDR_W-1:0] dest);
      int        gap;
      route_type r;
      if ($urandom_range(0, 39) == 0)
         burst_mode = !burst_mode;
      gap = burst_mode ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_operation       <= op;
      req_entry_index     <= slot;
      req_entry_prefix    <= e.prefix;
      req_entry_mask      <= e.mask;
      req_entry_next_hop  <= e.gateway;
      req_entry_interface <= e.iface;
      req_dest_address    <= dest;
      do
         @(posedge clock);
      while (busy);
      // accepted at this edge
      if (op == lpr_pkg::OP_WRITE) begin
         route_table[slot] = e;
         write_count++;
      end else begin
         r = best_route(dest);
         pending_routes.push_back(r);
         lookup_count++;
         if (r.found)
            routed_count++;
      end
   endtask

   task automatic send_write(input logic [lpr_pkg::SLOT_W-1:0] slot,
                             input lpr_pkg::entry_type e);
      send_request(lpr_pkg::OP_WRITE, slot, e, $urandom);
   endtask

   task automatic send_lookup(input logic [lpr_pkg::ADDR_W-1:0] dest);
      lpr_pkg::entry_type junk;
      junk.prefix  = $urandom;
      junk.mask    = $urandom;
      junk.gateway = $urandom;
      junk.iface   = lpr_pkg::IFACE_W'($urandom_range(0, 255));
      send_request(lpr_pkg::OP_LOOKUP, lpr_pkg::SLOT_W'($urandom_range(0, DEPTH - 1)),
                   junk, dest);
   endtask

   task automatic write_entry(input int slot, input logic [31:0] prefix,
                              input logic [31:0] mask, input logic [31:0] gateway,
                              input logic [7:0] iface);
      lpr_pkg::entry_type e;
      e.prefix  = prefix;
      e.mask    = mask;
      e.gateway = gateway;
      e.iface   = iface;
      send_write(slot[lpr_pkg::SLOT_W-1:0], e);
   endtask

   // Stop requests, wait for all responses, let a trailing write finish
   task automatic drain_responses();
      int waited;
      start  <= 1'b0;
      waited = 0;
      while (pending_routes.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_routes.size() > 0) begin
         report_mismatch("missing lookup responses, pending", 0, pending_routes.size());
         pending_routes.delete();
      end
      repeat (SETTLE) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Change the entry count with the unit idle
   task automatic set_entry_count(input logic [lpr_pkg::COUNT_W-1:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_entries = value;
      count_settings++;
   endtask

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_routes.size() == 0) begin
            report_mismatch("response with no lookup pending, next hop",
                            rsp_route_next_hop, 0);
         end else begin
            want_route = pending_routes.pop_front();
            if (rsp_route_found !== want_route.found)
               report_mismatch("route_found", rsp_route_found, want_route.found);
            if (rsp_route_index !== want_route.index)
               report_mismatch("route_index", rsp_route_index, want_route.index);
            if (rsp_route_next_hop !== want_route.gateway)
               report_mismatch("route_next_hop", rsp_route_next_hop,
                               want_route.gateway);
            if (rsp_route_interface !== want_route.iface)
               report_mismatch("route_interface", rsp_route_interface,
                               want_route.iface);
         end
      end
   end

   // Count is zero out of reset: nothing is searched
   task automatic test_reset_count();
      send_lookup(32'h0000_0000);
      send_lookup(32'hFFFF_FFFF);
   endtask

   // Hand-built table: default route, nested prefixes, tie, host route, odd mask
   task automatic test_directed_routes();
      write_entry(0,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
      write_entry(1,  32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 8'h01);
      write_entry(2,  32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 8'h02);
      write_entry(3,  32'h0A01_0100, 32'hFFFF_FF00, 32'h0A01_0101, 8'h03);
      write_entry(4,  32'h0A01_0100, 32'hFFFF_FF00, 32'h0A01_01FE, 8'h04);
      write_entry(5,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
      write_entry(6,  32'h0204_0608, 32'h0F0F_0F0F, 32'h5A5A_A5A5, 8'h66);
      write_entry(7,  32'hC0A8_0001, 32'hFFFF_0000, 32'h1234_5678, 8'h77);
      write_entry(63, 32'h7F00_0000, 32'hFF00_0000, 32'hDEAD_BEEF, 8'hAA);
      set_entry_count(7'd8);
      send_lookup(32'h0A01_0105);  // tie on equal masks, lower slot wins
      send_lookup(32'h0A01_FF00);
      send_lookup(32'h0AFF_FFFF);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h0000_0000);
      send_lookup(32'h72F4_A6B8);  // non-contiguous mask
      send_lookup(32'hC0A8_0001);  // prefix outside its mask never matches
      send_lookup(32'h7F00_0001);  // slot beyond the count is not searched
      set_entry_count(7'd1);
      send_lookup(32'h0A01_0105);
   endtask

   // Write every slot, then search the full table
   task automatic test_table_fill();
      for (int s = 0; s < DEPTH; s++)
         send_write(s[lpr_pkg::SLOT_W-1:0], make_entry());
      set_entry_count(DEPTH[lpr_pkg::COUNT_W-1:0]);
      repeat (20) send_lookup(pick_dest());
   endtask

   // Count above the table depth searches the whole table
   task automatic test_count_saturation();
      set_entry_count(7'd127);
      repeat (30) send_lookup(pick_dest());
      set_entry_count(7'd65);
      repeat (30) send_lookup(pick_dest());
   endtask

   // Mixed writes and lookups under a range of counts
   task automatic test_random_traffic();
      logic [lpr_pkg::COUNT_W-1:0] count;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       count = 7'd0;
            1:       count = 7'd127;
            2:       count = 7'd1;
            3:       count = DEPTH[lpr_pkg::COUNT_W-1:0];
            default: count = lpr_pkg::COUNT_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(65, 127)
                                               : $urandom_range(1, 64));
         endcase
         set_entry_count(count);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
               send_lookup(pick_dest());
            else
               send_write(lpr_pkg::SLOT_W'($urandom_range(0, DEPTH - 1)), make_entry());
         end
      end
   endtask

   // Main sequence
   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      start               = 1'b0;
      req_operation       = lpr_pkg::OP_WRITE;
      req_entry_index     = '0;
      req_entry_prefix    = '0;
      req_entry_mask      = '0;
      req_entry_next_hop  = '0;
      req_entry_interface = '0;
      req_dest_address    = '0;
      active_entries      = '0;
      error_count         = 0;
      write_count         = 0;
      lookup_count        = 0;
      routed_count        = 0;
      count_settings      = 0;
      burst_mode          = 1'b0;
      for (int s = 0; s < DEPTH; s++)
         route_table[s] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_count();
      test_directed_routes();
      test_table_fill();
      test_count_saturation();
      test_random_traffic();

      drain_responses();
      repeat (DEPTH + 4) @(posedge clock);

      $display("Run covered %0d table writes and %0d lookups (%0d routed, %0d unrouted)",
               write_count, lookup_count, routed_count, lookup_count - routed_count);
      $display("across %0d entry count settings, %0d mismatches", count_settings,
               error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
sv/lpr_pkg.sv
sv/longest_prefix_route_lookup_unit.sv
sv/lpr_checker.sv
tb/longest_prefix_route_lookup_unit_tb.sv
